### rtl/hlce_pkg.sv
// shared types and constants of the hashed lru cache engine
package hlce_pkg;

    localparam int SLOT_W  = 6;
    localparam logic [SLOT_W-1:0] SLOT_NIL = 6'h3F;
    localparam int BYTES_W = 37;
    localparam int KEY_W   = 64;
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_RELEASED = 2'd0,
        KIND_HIT      = 2'd1,
        KIND_MISS     = 2'd2,
        KIND_DONE     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_EVICT,
        PH_FULL,
        PH_REPLACE,
        PH_DELETE,
        PH_LOOKUP
    } phase_t;

    typedef enum logic [0:0] {
        CFG_BYTE_BUDGET = 1'b0,
        CFG_ENTRY_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_EVCHK,
        ST_FULLCHK,
        ST_POP_RD,
        ST_POP,
        ST_FHEAD,
        ST_FCHK,
        ST_FCMP,
        ST_REL_RD,
        ST_REL_UNL,
        ST_REL_FREE,
        ST_STORE,
        ST_LINK_RD,
        ST_LINK_A,
        ST_LINK_B,
        ST_OUT_RD,
        ST_OUT_SHOW,
        ST_OUT_FINAL
    } state_t;

endpackage

### rtl/hlce_ram.sv
// single write port, single registered read port memory
module hlce_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
    input  logic [W-1:0]                        wdata,
    input  logic                                re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
    output logic [W-1:0]                        rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/hlce_hash.sv
// bucket index unit: key_low modulo the bucket count
module hlce_hash #(
    parameter int BUCKETS = 64
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          start,
    input  logic [63:0]                                   key,
    output logic                                          done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);
    import hlce_pkg::*;

    localparam int  BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam bit  IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            logic          done_reg;
            logic [BW-1:0] bucket_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    bucket_reg <= key[BW-1:0];
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end else begin : g_div
            // one hex digit a cycle, restoring reduction against 8b, 4b, 2b, b
            localparam logic [BW+3:0] B1 = (BW+4)'(BUCKETS);
            localparam logic [BW+3:0] B2 = (BW+4)'(BUCKETS * 2);
            localparam logic [BW+3:0] B4 = (BW+4)'(BUCKETS * 4);
            localparam logic [BW+3:0] B8 = (BW+4)'(BUCKETS * 8);

            logic          busy_reg, busy_next;
            logic          done_reg, done_next;
            logic [3:0]    cnt_reg, cnt_next;
            logic [63:0]   sh_reg, sh_next;
            logic [BW-1:0] rem_reg, rem_next;
            logic [BW+3:0] t0, t1, t2, t3, t4;

            always_comb begin
                t0 = {rem_reg, sh_reg[63:60]};
                t1 = (t0 >= B8) ? t0 - B8 : t0;
                t2 = (t1 >= B4) ? t1 - B4 : t1;
                t3 = (t2 >= B2) ? t2 - B2 : t2;
                t4 = (t3 >= B1) ? t3 - B1 : t3;
                busy_next = busy_reg;
                done_next = 1'b0;
                cnt_next  = cnt_reg;
                sh_next   = sh_reg;
                rem_next  = rem_reg;
                if (start) begin
                    busy_next = 1'b1;
                    cnt_next  = '0;
                    sh_next   = key;
                    rem_next  = '0;
                end else if (busy_reg) begin
                    rem_next = t4[BW-1:0];
                    sh_next  = {sh_reg[59:0], 4'h0};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'hF) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end else begin
                    busy_reg <= busy_next;
                    done_reg <= done_next;
                    cnt_reg  <= cnt_next;
                end
                sh_reg  <= sh_next;
                rem_reg <= rem_next;
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
    endgenerate
endmodule

### rtl/hashed_lru_cache_engine.sv
// lru cache of 128-bit keys: slot pool, hashed bucket chains, age list
// a lookup hashes the key, reads the bucket head and walks the chain, reading and
// comparing each entry; an insert first evicts for the budget and a full pool, then
// stores and links; released items come from the release buffer; each item waits for m_tready
// the hash unit gives the bucket index: a mask for a power-of-two bucket count, else a reduction
// one item at a time; every list step is one registered read of a link memory
// after reset a clearing pass nulls every bucket head before the first item is
// taken; configuration writes are taken at any time
module hashed_lru_cache_engine #(
    parameter int SLOTS   = 32,
    parameter int BUCKETS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // key_low, key_high, data_handle, data_size
    input  logic [1:0]   s_tuser,   // operation
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // out_handle, out_size, entry_count, byte_total, pad
    output logic [1:0]   m_tuser,   // result_kind
    output logic         m_tlast
);
    import hlce_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW = BW + 2 * KEY_W + 2 * DATA_W;
    localparam logic [SLOT_W-1:0] SLOTS_C = SLOT_W'(SLOTS);
    localparam logic [BW-1:0]     LAST_BKT = BW'(BUCKETS - 1);

    function automatic logic is_slot(input logic [SLOT_W-1:0] s);
        return s < SLOTS_C;
    endfunction

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    kind_t  fin_reg, fin_next;

    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   kl_reg, kh_reg;
    logic [DATA_W-1:0]  hd_reg, sz_reg;
    logic [BW-1:0]      kb_reg, kb_next;
    logic [BW-1:0]      clr_reg, clr_next;
    logic [SLOT_W-1:0]  tgt_reg, tgt_next;
    logic [SLOT_W-1:0]  new_reg, new_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic               first_reg, first_next;
    logic [SLOT_W-1:0]  lk_slot_reg, lk_slot_next;
    logic [BW-1:0]      lk_bkt_reg, lk_bkt_next;
    logic [SLOT_W-1:0]  lk_head_reg, lk_head_next;
    logic [SLOT_W-1:0]  oldest_reg, oldest_next;
    logic [SLOT_W-1:0]  newest_reg, newest_next;
    logic [SLOT_W-1:0]  free_reg, free_next;
    logic [SLOT_W-1:0]  fresh_reg, fresh_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [SLOT_W-1:0]  entries_reg, entries_next;
    logic [SLOT_W-1:0]  rel_cnt_reg, rel_cnt_next;
    logic [SLOT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [31:0]        budget_reg;
    logic [SLOT_W-1:0]  elim_reg;
    logic [SLOT_W-1:0]  lim;

    logic               accept;
    logic               hash_done;
    logic [BW-1:0]      hash_bkt;

    // memory ports
    logic              rec_we, rec_re;
    logic [AW-1:0]     rec_wa, rec_ra;
    logic [RW-1:0]     rec_wd, rec_q;
    logic              cn_we, cn_re, cp_we, cp_re, an_we, an_re, ao_we, ao_re;
    logic [AW-1:0]     cn_wa, cn_ra, cp_wa, cp_ra, an_wa, an_ra, ao_wa, ao_ra;
    logic [SLOT_W-1:0] cn_wd, cn_q, cp_wd, cp_q, an_wd, an_q, ao_wd, ao_q;
    logic              bh_we, bh_re;
    logic [BW-1:0]     bh_wa, bh_ra;
    logic [SLOT_W-1:0] bh_wd, bh_q;
    logic              rb_we, rb_re;
    logic [AW-1:0]     rb_wa, rb_ra;
    logic [63:0]       rb_wd, rb_q;

    logic [BW-1:0]     rec_bkt;
    logic [KEY_W-1:0]  rec_kl, rec_kh;
    logic [DATA_W-1:0] rec_hd, rec_sz;
    logic [SLOT_W-1:0] walk_s;

    assign rec_sz  = rec_q[DATA_W-1:0];
    assign rec_hd  = rec_q[2*DATA_W-1:DATA_W];
    assign rec_kh  = rec_q[2*DATA_W+KEY_W-1:2*DATA_W];
    assign rec_kl  = rec_q[2*DATA_W+2*KEY_W-1:2*DATA_W+KEY_W];
    assign rec_bkt = rec_q[RW-1:2*DATA_W+2*KEY_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // clamp of the entry limit into 1..SLOTS
    always_comb begin
        if (elim_reg == '0) begin
            lim = SLOT_W'(1);
        end else if (elim_reg > SLOTS_C) begin
            lim = SLOTS_C;
        end else begin
            lim = elim_reg;
        end
    end

    hlce_hash #(.BUCKETS(BUCKETS)) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (s_tdata[63:0]),
        .done    (hash_done),
        .bucket  (hash_bkt)
    );

    hlce_ram #(.W(RW), .D(SLOTS)) u_rec (
        .aclk(aclk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
        .re(rec_re), .raddr(rec_ra), .rdata(rec_q)
    );
    hlce_ram #(.W(SLOT_W), .D(SLOTS)) u_cn (
        .aclk(aclk), .we(cn_we), .waddr(cn_wa), .wdata(cn_wd),
        .re(cn_re), .raddr(cn_ra), .rdata(cn_q)
    );
    hlce_ram #(.W(SLOT_W), .D(SLOTS)) u_cp (
        .aclk(aclk), .we(cp_we), .waddr(cp_wa), .wdata(cp_wd),
        .re(cp_re), .raddr(cp_ra), .rdata(cp_q)
    );
    hlce_ram #(.W(SLOT_W), .D(SLOTS)) u_an (
        .aclk(aclk), .we(an_we), .waddr(an_wa), .wdata(an_wd),
        .re(an_re), .raddr(an_ra), .rdata(an_q)
    );
    hlce_ram #(.W(SLOT_W), .D(SLOTS)) u_ao (
        .aclk(aclk), .we(ao_we), .waddr(ao_wa), .wdata(ao_wd),
        .re(ao_re), .raddr(ao_ra), .rdata(ao_q)
    );
    hlce_ram #(.W(SLOT_W), .D(BUCKETS)) u_bh (
        .aclk(aclk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd),
        .re(bh_re), .raddr(bh_ra), .rdata(bh_q)
    );
    hlce_ram #(.W(64), .D(SLOTS)) u_rb (
        .aclk(aclk), .we(rb_we), .waddr(rb_wa), .wdata(rb_wd),
        .re(rb_re), .raddr(rb_ra), .rdata(rb_q)
    );

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        fin_next     = fin_reg;
        kb_next      = kb_reg;
        clr_next     = clr_reg;
        tgt_next     = tgt_reg;
        new_next     = new_reg;
        cur_next     = cur_reg;
        first_next   = first_reg;
        lk_slot_next = lk_slot_reg;
        lk_bkt_next  = lk_bkt_reg;
        lk_head_next = lk_head_reg;
        oldest_next  = oldest_reg;
        newest_next  = newest_reg;
        free_next    = free_reg;
        fresh_next   = fresh_reg;
        bytes_next   = bytes_reg;
        entries_next = entries_reg;
        rel_cnt_next = rel_cnt_reg;
        rd_idx_next  = rd_idx_reg;

        rec_we = 1'b0; rec_wa = '0; rec_wd = '0; rec_re = 1'b0; rec_ra = '0;
        cn_we = 1'b0; cn_wa = '0; cn_wd = '0; cn_re = 1'b0; cn_ra = '0;
        cp_we = 1'b0; cp_wa = '0; cp_wd = '0; cp_re = 1'b0; cp_ra = '0;
        an_we = 1'b0; an_wa = '0; an_wd = '0; an_re = 1'b0; an_ra = '0;
        ao_we = 1'b0; ao_wa = '0; ao_wd = '0; ao_re = 1'b0; ao_ra = '0;
        bh_we = 1'b0; bh_wa = '0; bh_wd = '0; bh_re = 1'b0; bh_ra = '0;
        rb_we = 1'b0; rb_wa = '0; rb_wd = '0; rb_re = 1'b0; rb_ra = '0;

        walk_s = first_reg ? bh_q : cn_q;

        unique case (state_reg)
            ST_CLEAR: begin
                bh_we = 1'b1;
                bh_wa = clr_reg;
                bh_wd = SLOT_NIL;
                clr_next = clr_reg + BW'(1);
                if (clr_reg == LAST_BKT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    rel_cnt_next = '0;
                    rd_idx_next  = '0;
                    state_next   = ST_HASH;
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    kb_next = hash_bkt;
                    priority case (op_reg)
                        OP_INSERT: state_next = ST_EVCHK;
                        OP_LOOKUP, OP_DELETE: state_next = ST_FHEAD;
                        default: begin
                            fin_next   = KIND_DONE;
                            state_next = ST_OUT_FINAL;
                        end
                    endcase
                end
            end
            ST_EVCHK: begin
                if (is_slot(oldest_reg) && bytes_reg > BYTES_W'(budget_reg)) begin
                    tgt_next   = oldest_reg;
                    phase_next = PH_EVICT;
                    state_next = ST_REL_RD;
                end else begin
                    state_next = ST_FULLCHK;
                end
            end
            ST_FULLCHK: begin
                state_next = ST_POP_RD;
                if (!is_slot(free_reg)) begin
                    if (fresh_reg < lim) begin
                        cn_we      = 1'b1;
                        cn_wa      = fresh_reg[AW-1:0];
                        cn_wd      = SLOT_NIL;
                        free_next  = fresh_reg;
                        fresh_next = fresh_reg + SLOT_W'(1);
                    end else if (is_slot(oldest_reg)) begin
                        tgt_next   = oldest_reg;
                        phase_next = PH_FULL;
                        state_next = ST_REL_RD;
                    end
                end
            end
            ST_POP_RD: begin
                if (!is_slot(free_reg)) begin
                    fin_next   = KIND_DONE;
                    state_next = (rel_cnt_reg != '0) ? ST_OUT_RD : ST_OUT_FINAL;
                end else begin
                    new_next   = free_reg;
                    cn_re      = 1'b1;
                    cn_ra      = free_reg[AW-1:0];
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                free_next  = cn_q;
                state_next = ST_FHEAD;
            end
            ST_FHEAD: begin
                bh_re      = 1'b1;
                bh_ra      = kb_reg;
                first_next = 1'b1;
                state_next = ST_FCHK;
            end
            ST_FCHK: begin
                if (is_slot(walk_s)) begin
                    rec_re     = 1'b1;
                    rec_ra     = walk_s[AW-1:0];
                    cn_re      = 1'b1;
                    cn_ra      = walk_s[AW-1:0];
                    cur_next   = walk_s;
                    state_next = ST_FCMP;
                end else begin
                    // key not held
                    priority case (op_reg)
                        OP_INSERT: state_next = ST_STORE;
                        OP_LOOKUP: begin
                            fin_next   = KIND_MISS;
                            state_next = ST_OUT_FINAL;
                        end
                        default: begin
                            fin_next   = KIND_DONE;
                            state_next = ST_OUT_FINAL;
                        end
                    endcase
                end
            end
            ST_FCMP: begin
                if (rec_kl == kl_reg && rec_kh == kh_reg) begin
                    tgt_next   = cur_reg;
                    state_next = ST_REL_RD;
                    priority case (op_reg)
                        OP_INSERT: phase_next = PH_REPLACE;
                        OP_LOOKUP: phase_next = PH_LOOKUP;
                        default:   phase_next = PH_DELETE;
                    endcase
                end else begin
                    first_next = 1'b0;
                    state_next = ST_FCHK;
                end
            end
            ST_REL_RD: begin
                rec_re = 1'b1; rec_ra = tgt_reg[AW-1:0];
                cn_re  = 1'b1; cn_ra  = tgt_reg[AW-1:0];
                cp_re  = 1'b1; cp_ra  = tgt_reg[AW-1:0];
                an_re  = 1'b1; an_ra  = tgt_reg[AW-1:0];
                ao_re  = 1'b1; ao_ra  = tgt_reg[AW-1:0];
                state_next = ST_REL_UNL;
            end
            ST_REL_UNL: begin
                // unlink from age list and bucket chain, up to two link writes each
                if (is_slot(ao_q)) begin
                    an_we = 1'b1; an_wa = ao_q[AW-1:0]; an_wd = an_q;
                end else begin
                    oldest_next = an_q;
                end
                if (is_slot(an_q)) begin
                    ao_we = 1'b1; ao_wa = an_q[AW-1:0]; ao_wd = ao_q;
                end else begin
                    newest_next = ao_q;
                end
                if (is_slot(cp_q)) begin
                    cn_we = 1'b1; cn_wa = cp_q[AW-1:0]; cn_wd = cn_q;
                end else begin
                    bh_we = 1'b1; bh_wa = rec_bkt; bh_wd = cn_q;
                end
                if (is_slot(cn_q)) begin
                    cp_we = 1'b1; cp_wa = cn_q[AW-1:0]; cp_wd = cp_q;
                end
                if (phase_reg == PH_LOOKUP) begin
                    lk_slot_next = tgt_reg;
                    lk_bkt_next  = rec_bkt;
                    fin_next     = KIND_HIT;
                    state_next   = ST_LINK_RD;
                end else begin
                    state_next = ST_REL_FREE;
                end
            end
            ST_REL_FREE: begin
                cn_we = 1'b1; cn_wa = tgt_reg[AW-1:0]; cn_wd = free_reg;
                free_next  = tgt_reg;
                bytes_next = bytes_reg - BYTES_W'(rec_sz);
                if (entries_reg != '0) begin
                    entries_next = entries_reg - SLOT_W'(1);
                end
                rb_we = 1'b1;
                rb_wa = rel_cnt_reg[AW-1:0];
                rb_wd = {rec_hd, rec_sz};
                rel_cnt_next = rel_cnt_reg + SLOT_W'(1);
                priority case (phase_reg)
                    PH_EVICT:   state_next = ST_EVCHK;
                    PH_FULL:    state_next = ST_POP_RD;
                    PH_REPLACE: state_next = ST_STORE;
                    default: begin
                        fin_next   = KIND_DONE;
                        state_next = ST_OUT_RD;
                    end
                endcase
            end
            ST_STORE: begin
                rec_we = 1'b1;
                rec_wa = new_reg[AW-1:0];
                rec_wd = {kb_reg, kl_reg, kh_reg, hd_reg, sz_reg};
                bytes_next   = bytes_reg + BYTES_W'(sz_reg);
                entries_next = entries_reg + SLOT_W'(1);
                lk_slot_next = new_reg;
                lk_bkt_next  = kb_reg;
                fin_next     = KIND_DONE;
                state_next   = ST_LINK_RD;
            end
            ST_LINK_RD: begin
                bh_re      = 1'b1;
                bh_ra      = lk_bkt_reg;
                state_next = ST_LINK_A;
            end
            ST_LINK_A: begin
                cp_we = 1'b1; cp_wa = lk_slot_reg[AW-1:0]; cp_wd = SLOT_NIL;
                cn_we = 1'b1; cn_wa = lk_slot_reg[AW-1:0]; cn_wd = bh_q;
                bh_we = 1'b1; bh_wa = lk_bkt_reg;          bh_wd = lk_slot_reg;
                an_we = 1'b1; an_wa = lk_slot_reg[AW-1:0]; an_wd = SLOT_NIL;
                ao_we = 1'b1; ao_wa = lk_slot_reg[AW-1:0]; ao_wd = newest_reg;
                lk_head_next = bh_q;
                state_next   = ST_LINK_B;
            end
            ST_LINK_B: begin
                if (is_slot(lk_head_reg)) begin
                    cp_we = 1'b1; cp_wa = lk_head_reg[AW-1:0]; cp_wd = lk_slot_reg;
                end
                if (is_slot(newest_reg)) begin
                    an_we = 1'b1; an_wa = newest_reg[AW-1:0]; an_wd = lk_slot_reg;
                end else begin
                    oldest_next = lk_slot_reg;
                end
                newest_next = lk_slot_reg;
                state_next  = (rel_cnt_reg != '0) ? ST_OUT_RD : ST_OUT_FINAL;
            end
            ST_OUT_RD: begin
                rb_re      = 1'b1;
                rb_ra      = rd_idx_reg[AW-1:0];
                state_next = ST_OUT_SHOW;
            end
            ST_OUT_SHOW: begin
                if (m_tready) begin
                    rd_idx_next = rd_idx_reg + SLOT_W'(1);
                    state_next  = (rd_idx_next == rel_cnt_reg) ? ST_OUT_FINAL : ST_OUT_RD;
                end
            end
            ST_OUT_FINAL: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            phase_reg   <= PH_EVICT;
            fin_reg     <= KIND_DONE;
            clr_reg     <= '0;
            first_reg   <= 1'b0;
            oldest_reg  <= SLOT_NIL;
            newest_reg  <= SLOT_NIL;
            free_reg    <= SLOT_NIL;
            fresh_reg   <= '0;
            bytes_reg   <= '0;
            entries_reg <= '0;
            rel_cnt_reg <= '0;
            rd_idx_reg  <= '0;
            budget_reg  <= 32'hFFFF_FFFF;
            elim_reg    <= SLOT_W'(32);
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            fin_reg     <= fin_next;
            clr_reg     <= clr_next;
            first_reg   <= first_next;
            oldest_reg  <= oldest_next;
            newest_reg  <= newest_next;
            free_reg    <= free_next;
            fresh_reg   <= fresh_next;
            bytes_reg   <= bytes_next;
            entries_reg <= entries_next;
            rel_cnt_reg <= rel_cnt_next;
            rd_idx_reg  <= rd_idx_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BYTE_BUDGET: budget_reg <= cfg_wdata;
                    CFG_ENTRY_LIMIT: elim_reg   <= cfg_wdata[SLOT_W-1:0];
                    default: ;
                endcase
            end
        end
        if (accept) begin
            op_reg <= s_tuser;
            kl_reg <= s_tdata[63:0];
            kh_reg <= s_tdata[127:64];
            hd_reg <= s_tdata[159:128];
            sz_reg <= s_tdata[191:160];
        end
        kb_reg      <= kb_next;
        tgt_reg     <= tgt_next;
        new_reg     <= new_next;
        cur_reg     <= cur_next;
        lk_slot_reg <= lk_slot_next;
        lk_bkt_reg  <= lk_bkt_next;
        lk_head_reg <= lk_head_next;
    end

    // result item assembly
    logic [DATA_W-1:0] o_hd, o_sz;
    kind_t             o_kind;

    always_comb begin
        if (state_reg == ST_OUT_SHOW) begin
            o_kind = KIND_RELEASED;
            o_hd   = rb_q[63:32];
            o_sz   = rb_q[31:0];
        end else begin
            o_kind = fin_reg;
            o_hd   = (fin_reg == KIND_HIT) ? rec_hd : '0;
            o_sz   = (fin_reg == KIND_HIT) ? rec_sz : '0;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT_SHOW) || (state_reg == ST_OUT_FINAL);
    assign m_tlast  = (state_reg == ST_OUT_FINAL);
    assign m_tuser  = o_kind;
    assign m_tdata  = {5'b0, bytes_reg, entries_reg, o_sz, o_hd};

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the hashed lru cache engine
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hlce_pkg::*;

    localparam int NSLOT = 32;
    localparam int NBUCK = 64;
    localparam logic [5:0] NUL = 6'h3F;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] handle;
        logic [31:0] size;
        logic [5:0]  count;
        logic [36:0] bytes;
        logic        last;
    } result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [0:0] cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [191:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    hashed_lru_cache_engine u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial forever #5 aclk = ~aclk;

    // cache shadow
    logic [63:0] c_kl[NSLOT], c_kh[NSLOT];
    logic [31:0] c_hd[NSLOT], c_sz[NSLOT];
    logic [5:0] c_nx[NSLOT], c_pv[NSLOT], c_nw[NSLOT], c_od[NSLOT];
    logic [5:0] c_head[NBUCK];
    logic [5:0] c_oldest, c_newest, c_free, c_fresh, c_count;
    logic [36:0] c_bytes;
    logic [31:0] c_budget;
    logic [5:0] c_limit;

    result_t expected_results[$];
    result_t step_buf[$];
    int errors = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    int n_items = 0;

    // recent inserted keys, up to 48, so lookups and deletes hit
    logic [63:0] recent_kl[$], recent_kh[$];

    function automatic bit ok(logic [5:0] s);
        return s < NSLOT;
    endfunction

    function automatic int bucket_of(logic [63:0] kl);
        return int'(kl[5:0]);
    endfunction

    task automatic shadow_reset();
        for (int i = 0; i < NBUCK; i++) c_head[i] = NUL;
        for (int i = 0; i < NSLOT; i++) begin
            c_nx[i] = NUL; c_pv[i] = NUL; c_nw[i] = NUL; c_od[i] = NUL;
            c_kl[i] = '0; c_kh[i] = '0; c_hd[i] = '0; c_sz[i] = '0;
        end
        c_oldest = NUL; c_newest = NUL; c_free = NUL; c_fresh = '0;
        c_count = '0; c_bytes = '0; c_budget = 32'hFFFF_FFFF; c_limit = 6'd32;
    endtask

    function automatic void emit(logic [1:0] k, logic [31:0] h, logic [31:0] s);
        result_t r;
        r = '0; r.kind = k; r.handle = h; r.size = s;
        step_buf.push_back(r);
    endfunction

    function automatic void age_unlink(logic [5:0] s);
        logic [5:0] o, n, p, x;
        o = c_od[s]; n = c_nw[s]; p = c_pv[s]; x = c_nx[s];
        if (ok(o)) c_nw[o] = n; else c_oldest = n;
        if (ok(n)) c_od[n] = o; else c_newest = o;
        if (ok(p)) c_nx[p] = x; else c_head[bucket_of(c_kl[s])] = x;
        if (ok(x)) c_pv[x] = p;
    endfunction

    function automatic void age_link(logic [5:0] s);
        int b;
        logic [5:0] h;
        b = bucket_of(c_kl[s]); h = c_head[b];
        c_pv[s] = NUL; c_nx[s] = h;
        if (ok(h)) c_pv[h] = s;
        c_head[b] = s;
        c_nw[s] = NUL; c_od[s] = c_newest;
        if (ok(c_newest)) c_nw[c_newest] = s; else c_oldest = s;
        c_newest = s;
    endfunction

    function automatic void free_slot(logic [5:0] s);
        age_unlink(s);
        c_bytes = c_bytes - 37'(c_sz[s]);
        if (c_count > 0) c_count--;
        c_nx[s] = c_free; c_free = s;
        emit(KIND_RELEASED, c_hd[s], c_sz[s]);
    endfunction

    function automatic logic [5:0] find_key(logic [63:0] kl, logic [63:0] kh);
        logic [5:0] s;
        int g;
        s = c_head[bucket_of(kl)]; g = 0;
        while (ok(s) && g <= NSLOT) begin
            if (c_kl[s] == kl && c_kh[s] == kh) return s;
            s = c_nx[s]; g++;
        end
        return NUL;
    endfunction

    function automatic void cache_insert(logic [63:0] kl, logic [63:0] kh,
                                         logic [31:0] h, logic [31:0] sz);
        int lim;
        logic [5:0] s, old;
        lim = c_limit;
        if (lim < 1) lim = 1;
        if (lim > NSLOT) lim = NSLOT;
        while (ok(c_oldest) && c_bytes > {5'd0, c_budget}) free_slot(c_oldest);
        if (!ok(c_free)) begin
            if (c_fresh < lim) begin
                c_nx[c_fresh] = NUL; c_free = c_fresh; c_fresh++;
            end else if (ok(c_oldest)) begin
                free_slot(c_oldest);
            end
        end
        if (!ok(c_free)) return;
        s = c_free; c_free = c_nx[s];
        old = find_key(kl, kh);
        if (ok(old)) free_slot(old);
        c_kl[s] = kl; c_kh[s] = kh; c_hd[s] = h; c_sz[s] = sz;
        age_link(s);
        c_bytes = c_bytes + 37'(sz);
        if (c_count < 63) c_count++;
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [63:0] kl, logic [63:0] kh,
                                         logic [31:0] h, logic [31:0] sz);
        logic [5:0] s;
        result_t r;
        step_buf.delete();
        case (op)
            OP_INSERT: begin
                cache_insert(kl, kh, h, sz);
                emit(KIND_DONE, 0, 0);
            end
            OP_LOOKUP: begin
                s = find_key(kl, kh);
                if (ok(s)) begin
                    age_unlink(s); age_link(s);
                    emit(KIND_HIT, c_hd[s], c_sz[s]);
                end else begin
                    emit(KIND_MISS, 0, 0);
                end
            end
            OP_DELETE: begin
                s = find_key(kl, kh);
                if (ok(s)) free_slot(s);
                emit(KIND_DONE, 0, 0);
            end
            default: emit(KIND_DONE, 0, 0);
        endcase
        for (int k = 0; k < step_buf.size(); k++) begin
            r = step_buf[k];
            r.count = c_count; r.bytes = c_bytes;
            r.last = (k == step_buf.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
        errors++;
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                w = expected_results.pop_front();
                if (m_tuser !== w.kind) report_mismatch("kind", m_tuser, w.kind);
                if (m_tdata[31:0] !== w.handle) report_mismatch("handle", m_tdata[31:0], w.handle);
                if (m_tdata[63:32] !== w.size) report_mismatch("size", m_tdata[63:32], w.size);
                if (m_tdata[69:64] !== w.count) report_mismatch("count", m_tdata[69:64], w.count);
                if (m_tdata[106:70] !== w.bytes) report_mismatch("bytes", m_tdata[106:70], w.bytes);
                if (m_tlast !== w.last) report_mismatch("last", m_tlast, w.last);
            end
            results_seen++;
        end
    end

    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 3) m_tready <= 1'b0;
        else if (!m_tready && $urandom_range(0, 99) < 15) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) < 75) || !m_tready;
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || hold_off)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [63:0] kl, logic [63:0] kh,
                             logic [31:0] h, logic [31:0] sz);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // the valid drop of the previous item owns the current falling edge
        repeat (gap + 1) @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {sz, h, kh, kl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(op, kl, kh, h, sz);
        n_items++;
        if (op == OP_INSERT) begin
            recent_kl.push_back(kl); recent_kh.push_back(kh);
            if (recent_kl.size() > 48) begin
                void'(recent_kl.pop_front()); void'(recent_kh.pop_front());
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BYTE_BUDGET) c_budget = v; else c_limit = v[5:0];
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_item(int bucket_span);
        int pick;
        logic [63:0] kl, kh;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        op = (pick < 50) ? OP_INSERT : (pick < 78) ? OP_LOOKUP : (pick < 97) ? OP_DELETE : 2'd3;
        if (recent_kl.size() > 0 && $urandom_range(0, 99) < 55) begin
            pick = $urandom_range(0, recent_kl.size() - 1);
            kl = recent_kl[pick]; kh = recent_kh[pick];
            // same low word, other high word: same bucket, different key
            if ($urandom_range(0, 9) == 0) kh = kh ^ 64'h1;
        end else begin
            kl = rand64(); kh = rand64();
            kl[5:0] = 6'($urandom_range(0, bucket_span - 1));
        end
        send_item(op, kl, kh, $urandom(),
                  ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 4000));
    endtask

    task automatic test_directed();
        send_item(OP_LOOKUP, 0, 0, 0, 0);
        send_item(OP_DELETE, 0, 0, 0, 0);
        send_item(OP_INSERT, 0, 0, 0, 0);
        send_item(OP_INSERT, '1, '1, '1, '1);
        send_item(OP_INSERT, 64'h40, 64'h5, 32'hA5A5_5A5A, 100);
        send_item(OP_INSERT, 64'h80, 64'h5, 32'h5A5A_A5A5, 200);
        send_item(OP_LOOKUP, 64'h40, 64'h5, 0, 0);
        send_item(OP_LOOKUP, 64'h40, 64'h6, 0, 0);
        send_item(OP_INSERT, 64'h40, 64'h5, 32'h1234, 300);
        send_item(OP_DELETE, 64'h80, 64'h5, 0, 0);
        send_item(OP_DELETE, 64'h80, 64'h5, 0, 0);
        send_item(2'd3, '1, '1, '1, '1);
        send_item(OP_LOOKUP, '1, '1, 0, 0);
        send_item(OP_INSERT, 64'h7, 0, 32'h77, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 64'h8, 0, 32'h88, 10);
        drain();
    endtask

    task automatic test_budget();
        write_reg(CFG_BYTE_BUDGET, 0);
        for (int i = 0; i < 6; i++) random_item(64);
        drain();
        write_reg(CFG_BYTE_BUDGET, 5000);
        for (int i = 0; i < 60; i++) random_item(64);
        drain();
        write_reg(CFG_BYTE_BUDGET, 32'hFFFF_FFFF);
    endtask

    task automatic test_entry_limit();
        write_reg(CFG_ENTRY_LIMIT, 0);
        for (int i = 0; i < 8; i++) random_item(4);
        drain();
        write_reg(CFG_ENTRY_LIMIT, 3);
        for (int i = 0; i < 30; i++) random_item(4);
        drain();
        write_reg(CFG_ENTRY_LIMIT, 6'h3F);
        for (int i = 0; i < 30; i++) random_item(8);
        drain();
        write_reg(CFG_ENTRY_LIMIT, 32);
    endtask

    task automatic test_full_pool();
        // many inserts fill the pool and evict from the old end, then a one-byte budget flushes all
        for (int i = 0; i < 50; i++)
            send_item(OP_INSERT, rand64(), rand64(), $urandom(), $urandom_range(0, 50));
        drain();
        write_reg(CFG_BYTE_BUDGET, 1);
        send_item(OP_INSERT, rand64(), rand64(), $urandom(), 2);
        send_item(OP_INSERT, rand64(), rand64(), $urandom(), 2);
        drain();
        write_reg(CFG_BYTE_BUDGET, 32'hFFFF_FFFF);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++) random_item(16);
        join
        drain();
    endtask

    task automatic test_random();
        for (int i = 0; i < 160; i++) random_item((i % 3 == 0) ? 64 : 8);
        drain();
    endtask

    initial begin
        shadow_reset();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_budget();
        test_entry_limit();
        test_full_pool();
        test_backpressure();
        test_random();
        $display("sent %0d items, checked %0d results", n_items, results_seen);
        $display("covered inserts, lookups, deletes, budget and limit extremes, full pool, stalls");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### files.f
rtl/hlce_pkg.sv
rtl/hlce_ram.sv
rtl/hlce_hash.sv
rtl/hashed_lru_cache_engine.sv
tb/sv/testbench.sv
